/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks that vanish when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* rtl/cfcd_pkg.sv */
// ----------------------------------------------------------------------------
// cfcd_pkg
// types, codes and the crc-8 byte fold for the command frame decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfcd_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned COUNT_W  = 3;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned OUT_W    = STATUS_W + 1 + BYTE_W + VALUE_W;
	localparam int unsigned OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

	localparam logic [BYTE_W-1:0]  CRC_POLY   = 8'h07;
	localparam logic [BYTE_W-1:0]  CRC_INIT   = 8'h00;
	localparam logic [COUNT_W-1:0] COUNT_MAX  = 3'd7;
	localparam logic [COUNT_W-1:0] READ_DATA  = 3'd1;
	localparam logic [COUNT_W-1:0] WRITE_DATA = 3'd5;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK      = 2'd0,
		STATUS_CRC_ERR = 2'd1,
		STATUS_LEN_ERR = 2'd2
	} status_t;

	typedef enum logic {
		CMD_READ  = 1'b0,
		CMD_WRITE = 1'b1
	} command_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [BYTE_W-1:0]  address;
		command_t           command;
		status_t            status;
	} result_t;

	// crc-8, msb first, one byte folded in
	function automatic logic [BYTE_W-1:0] crc8_fold(
		input logic [BYTE_W-1:0] crc,
		input logic [BYTE_W-1:0] data
	);
		logic [BYTE_W-1:0] c;
		c = crc ^ data;
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[BYTE_W-1]) begin
				c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[BYTE_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

/* rtl/command_frame_crc8_decoder_unit.sv */
// ----------------------------------------------------------------------------
// command_frame_crc8_decoder_unit
// streaming decoder for crc-8 protected read and write command frames
// ----------------------------------------------------------------------------
// The unit takes one received byte per item on the slave stream, with tlast
// marking the trailing crc byte of a frame. Earlier bytes are folded into a
// crc-8 (poly 0x07, init 0, msb first, no final xor); byte 0 is the address
// and bytes 1 to 4 a big-endian value. On the crc byte one result item leaves
// on the master stream: crc error if the crc byte does not match, else a read
// for a 2-byte frame, a write for a 6-byte frame, or a length error. Error
// results carry zero command, address and value. Throughput is one byte per
// cycle; a crc byte passes the input register, then the crc fold and the result
// register, before its result item leaves on the master stream.
// The only stall is a held result item that the sink has not yet taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module command_frame_crc8_decoder_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// slave stream: received bytes
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [cfcd_pkg::BYTE_W-1:0]          s_axis_tdata,  // [7:0] rx_byte
	input  logic                                 s_axis_tlast,  // frame_end
	// master stream: decoded commands
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// [1:0] status, [2] command, [10:3] address, [42:11] value, [47:43] zero
	output logic [cfcd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

	// input register
	logic                         in_valid_s1;
	logic [cfcd_pkg::BYTE_W-1:0]  in_byte_s1;
	logic                         in_last_s1;

	// frame state
	logic [cfcd_pkg::BYTE_W-1:0]  crc_q;
	logic [cfcd_pkg::COUNT_W-1:0] count_q;
	logic [cfcd_pkg::BYTE_W-1:0]  addr_q;
	logic [cfcd_pkg::VALUE_W-1:0] value_q;

	// result register
	logic                         out_valid_s2;
	cfcd_pkg::result_t            out_res_s2;

	logic                         s1_advance;
	logic                         s1_take;
	cfcd_pkg::result_t            res_next;

	// the whole pipe moves unless a result item waits on the sink
	assign s1_advance    = !out_valid_s2 || m_axis_tready;
	assign s1_take       = in_valid_s1 && s1_advance;
	assign s_axis_tready = !in_valid_s1 || s1_advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	// byte payload needs no reset
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			in_byte_s1 <= s_axis_tdata;
			in_last_s1 <= s_axis_tlast;
		end
	end

	// decide the result of a crc byte against the running frame state
	always_comb begin
		res_next.status  = cfcd_pkg::STATUS_OK;
		res_next.command = cfcd_pkg::CMD_READ;
		res_next.address = '0;
		res_next.value   = '0;
		if (in_byte_s1 != crc_q) begin
			res_next.status = cfcd_pkg::STATUS_CRC_ERR;
		end else if (count_q == cfcd_pkg::READ_DATA) begin
			res_next.address = addr_q;
		end else if (count_q == cfcd_pkg::WRITE_DATA) begin
			res_next.command = cfcd_pkg::CMD_WRITE;
			res_next.address = addr_q;
			res_next.value   = value_q;
		end else begin
			res_next.status = cfcd_pkg::STATUS_LEN_ERR;
		end
	end

	// frame state: fold data bytes in, clear on the crc byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= cfcd_pkg::CRC_INIT;
			count_q <= '0;
			addr_q  <= '0;
			value_q <= '0;
		end else if (s1_take) begin
			if (in_last_s1) begin
				crc_q   <= cfcd_pkg::CRC_INIT;
				count_q <= '0;
				addr_q  <= '0;
				value_q <= '0;
			end else begin
				crc_q <= cfcd_pkg::crc8_fold(crc_q, in_byte_s1);
				if (count_q == '0) begin
					addr_q <= in_byte_s1;
				end else begin
					value_q <= {value_q[cfcd_pkg::VALUE_W-cfcd_pkg::BYTE_W-1:0], in_byte_s1};
				end
				// count saturates so long frames stay length errors
				if (count_q != cfcd_pkg::COUNT_MAX) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (s1_advance) begin
			out_valid_s2 <= in_valid_s1 && in_last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take && in_last_s1) begin
			out_res_s2 <= res_next;
		end
	end

	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tdata  = {{(cfcd_pkg::OUT_TDATA_W - cfcd_pkg::OUT_W){1'b0}}, out_res_s2};

	// checks
	`ASSERT_IMPLY(a_err_zero_payload, clk, arst_n,
		out_valid_s2 && (out_res_s2.status != cfcd_pkg::STATUS_OK),
		(out_res_s2.command == cfcd_pkg::CMD_READ) && (out_res_s2.address == '0)
			&& (out_res_s2.value == '0),
		"error result carries payload")
	`ASSERT_IMPLY(a_write_is_ok, clk, arst_n,
		out_valid_s2 && (out_res_s2.command == cfcd_pkg::CMD_WRITE),
		out_res_s2.status == cfcd_pkg::STATUS_OK,
		"write result with bad status")
	`ASSERT_IMPLY(a_read_zero_value, clk, arst_n,
		out_valid_s2 && (out_res_s2.status == cfcd_pkg::STATUS_OK)
			&& (out_res_s2.command == cfcd_pkg::CMD_READ),
		out_res_s2.value == '0,
		"read result with nonzero value")
	`ASSERT_NEXT(a_crc_byte_clears, clk, arst_n,
		s1_take && in_last_s1,
		out_valid_s2 && (count_q == '0) && (crc_q == cfcd_pkg::CRC_INIT),
		"crc byte did not give a result and clear the frame")
	`ASSERT_ALWAYS(a_status_code, clk, arst_n,
		!out_valid_s2 || (out_res_s2.status != 2'd3),
		"undefined status code")

endmodule
